// ===== design/gfau_pkg.sv =====
// ----------------------------------------------------------------------------
// gfau_pkg
// Types, operation codes and field arithmetic for the GF(2^8) arithmetic unit.
// ----------------------------------------------------------------------------
package gfau_pkg;

   localparam int GF_BITS = 8;

   localparam logic [7:0] GF_POLY_LOW = 8'h63;
   localparam logic [7:0] GF_TOP_BIT  = 8'h80;
   localparam logic [7:0] GF_ONE      = 8'h01;
   localparam logic [7:0] GF_INV_EXPO = 8'd254;

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_MUL = 3'd1;
   localparam logic [2:0] ACT_DIV = 3'd2;
   localparam logic [2:0] ACT_INV = 3'd3;
   localparam logic [2:0] ACT_POW = 3'd4;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
   } req_word_type;

   typedef struct packed {
      logic [7:0] result;
      logic       zero_divisor;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] operand_a;
      logic [7:0] operand_b;
      logic [7:0] expo;
      logic [7:0] sq;
      logic [7:0] acc;
   } pow_word_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = '0;
      x   = a;
      for (int k = 0; k < GF_BITS; k++) begin
         if (b[k]) begin
            acc = acc ^ x;
         end
         if ((x & GF_TOP_BIT) != 8'h00) begin
            x = {x[6:0], 1'b0} ^ GF_POLY_LOW;
         end else begin
            x = {x[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== design/gf256_arith_unit.sv =====
// ----------------------------------------------------------------------------
// gf256_arith_unit
// GF(2^8) add, multiply, divide, inverse and power, reduction byte 0x63.
// Pipeline: decode, eight square-and-multiply stages, final product stage;
// throughput one word per cycle while rsp_ready does not stall the output.
// Each stage holds one word; each square-and-multiply stage has a multiply pair.
// Synchronous reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module gf256_arith_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gfau_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output gfau_pkg::rsp_word_type rsp_word
);
   import gfau_pkg::*;

   logic         stg_valid [GF_BITS+1];
   logic         stg_ready [GF_BITS+1];
   pow_word_type stg_word  [GF_BITS+1];

   gfau_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (req_valid),
      .ready_out (req_ready),
      .word_in   (req_word),
      .valid_out (stg_valid[0]),
      .ready_in  (stg_ready[0]),
      .word_out  (stg_word[0])
   );

   for (genvar i = 0; i < GF_BITS; i++) begin : g_pow
      gfau_pow_stage u_pow_stage (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (stg_valid[i]),
         .ready_out (stg_ready[i]),
         .word_in   (stg_word[i]),
         .valid_out (stg_valid[i+1]),
         .ready_in  (stg_ready[i+1]),
         .word_out  (stg_word[i+1])
      );
   end

   gfau_final u_final (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (stg_valid[GF_BITS]),
      .ready_out (stg_ready[GF_BITS]),
      .word_in   (stg_word[GF_BITS]),
      .valid_out (rsp_valid),
      .ready_in  (rsp_ready),
      .word_out  (rsp_word)
   );

endmodule

// ===== design/gfau_decode.sv =====
// ----------------------------------------------------------------------------
// gfau_decode
// Entry stage: pick base and exponent for the square-and-multiply chain.
// ----------------------------------------------------------------------------
module gfau_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   output logic                   ready_out,
   input  gfau_pkg::req_word_type word_in,
   output logic                   valid_out,
   input  logic                   ready_in,
   output gfau_pkg::pow_word_type word_out
);
   import gfau_pkg::*;

   logic         valid_ff;
   logic         valid_in_w;
   pow_word_type word_ff;
   pow_word_type word_in_w;
   logic         load;

   assign ready_out = !valid_ff || ready_in;
   assign load      = valid_in && ready_out;

   always_comb begin
      word_in_w.action    = word_in.action;
      word_in_w.operand_a = word_in.operand_a;
      word_in_w.operand_b = word_in.operand_b;
      word_in_w.acc       = GF_ONE;
      case (word_in.action)
         ACT_POW: begin
            word_in_w.sq   = word_in.operand_a;
            word_in_w.expo = word_in.operand_b;
         end
         ACT_INV: begin
            word_in_w.sq   = word_in.operand_a;
            word_in_w.expo = GF_INV_EXPO;
         end
         ACT_DIV: begin
            word_in_w.sq   = word_in.operand_b;
            word_in_w.expo = GF_INV_EXPO;
         end
         ACT_MUL: begin
            word_in_w.sq   = word_in.operand_b;
            word_in_w.expo = GF_ONE;
         end
         default: begin
            word_in_w.sq   = word_in.operand_b;
            word_in_w.expo = word_in.operand_b;
         end
      endcase
   end

   assign valid_in_w = load ? 1'b1 : (valid_ff && !ready_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_w;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;

endmodule

// ===== design/gfau_pow_stage.sv =====
// ----------------------------------------------------------------------------
// gfau_pow_stage
// One square-and-multiply step: consume the low exponent bit.
// ----------------------------------------------------------------------------
module gfau_pow_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   output logic                   ready_out,
   input  gfau_pkg::pow_word_type word_in,
   output logic                   valid_out,
   input  logic                   ready_in,
   output gfau_pkg::pow_word_type word_out
);
   import gfau_pkg::*;

   logic         valid_ff;
   logic         valid_in_w;
   pow_word_type word_ff;
   pow_word_type word_in_w;
   logic         load;

   assign ready_out = !valid_ff || ready_in;
   assign load      = valid_in && ready_out;

   always_comb begin
      word_in_w      = word_in;
      word_in_w.acc  = word_in.expo[0] ? gf_mul(word_in.acc, word_in.sq) : word_in.acc;
      word_in_w.sq   = gf_mul(word_in.sq, word_in.sq);
      word_in_w.expo = {1'b0, word_in.expo[7:1]};
   end

   assign valid_in_w = load ? 1'b1 : (valid_ff && !ready_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_w;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;

endmodule

// ===== design/gfau_final.sv =====
// ----------------------------------------------------------------------------
// gfau_final
// Last stage: final product, zero checks and the output register.
// ----------------------------------------------------------------------------
module gfau_final (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   output logic                   ready_out,
   input  gfau_pkg::pow_word_type word_in,
   output logic                   valid_out,
   input  logic                   ready_in,
   output gfau_pkg::rsp_word_type word_out
);
   import gfau_pkg::*;

   logic         valid_ff;
   logic         valid_in_w;
   rsp_word_type word_ff;
   rsp_word_type word_in_w;
   logic         load;

   assign ready_out = !valid_ff || ready_in;
   assign load      = valid_in && ready_out;

   always_comb begin
      word_in_w.result       = '0;
      word_in_w.zero_divisor = 1'b0;
      case (word_in.action)
         ACT_ADD: begin
            word_in_w.result = word_in.operand_a ^ word_in.operand_b;
         end
         ACT_MUL: begin
            word_in_w.result = gf_mul(word_in.operand_a, word_in.acc);
         end
         ACT_DIV: begin
            if (word_in.operand_b == 8'h00) begin
               word_in_w.zero_divisor = 1'b1;
            end else begin
               word_in_w.result = gf_mul(word_in.operand_a, word_in.acc);
            end
         end
         ACT_INV: begin
            if (word_in.operand_a == 8'h00) begin
               word_in_w.zero_divisor = 1'b1;
            end else begin
               word_in_w.result = word_in.acc;
            end
         end
         ACT_POW: begin
            word_in_w.result = word_in.acc;
         end
         default: begin
            word_in_w.result = '0;
         end
      endcase
   end

   assign valid_in_w = load ? 1'b1 : (valid_ff && !ready_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_w;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in_w;
      end
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;

endmodule
